>>> rtl/rrmq_pkg.sv
// ----------------------------------------------------------------------------
// rrmq_pkg
// Shared codes and types of the rectangle range-minimum quadtree block.
// ----------------------------------------------------------------------------
package rrmq_pkg;

  // Operation codes carried by an input word.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Width of the signed price field.
  localparam int unsigned PRICE_W = 32;

  // Walker states, one-hot.
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

>>> rtl/rrmq_if.sv
// ----------------------------------------------------------------------------
// rrmq_if
// Request and result channels of the range-minimum quadtree block.
// ----------------------------------------------------------------------------
interface rrmq_in_if #(
  parameter int unsigned COORD_BITS = 5
);
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [COORD_BITS-1:0]          point_x;
  logic [COORD_BITS-1:0]          point_y;
  logic signed [rrmq_pkg::PRICE_W-1:0] point_price;
  logic [COORD_BITS-1:0]          x_low;
  logic [COORD_BITS-1:0]          x_high;
  logic [COORD_BITS-1:0]          y_low;
  logic [COORD_BITS-1:0]          y_high;

  modport source (output valid, operation, point_x, point_y, point_price,
                  x_low, x_high, y_low, y_high, input ready);
  modport sink   (input valid, operation, point_x, point_y, point_price,
                  x_low, x_high, y_low, y_high, output ready);
endinterface

interface rrmq_out_if #(
  parameter int unsigned COORD_BITS = 5
);
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic signed [rrmq_pkg::PRICE_W-1:0] best_price;
  logic [COORD_BITS-1:0]          best_x;
  logic [COORD_BITS-1:0]          best_y;

  modport source (output valid, found, best_price, best_x, best_y, input ready);
  modport sink   (input valid, found, best_price, best_x, best_y, output ready);
endinterface

>>> rtl/rrmq_node_ram.sv
// ----------------------------------------------------------------------------
// rrmq_node_ram
// Single-port node store with a registered read, one word per tree node.
// ----------------------------------------------------------------------------
module rrmq_node_ram #(
  parameter int unsigned DEPTH = 1365,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = 59
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rrmq_walker.sv
// ----------------------------------------------------------------------------
// rrmq_walker
// Sequencer that clears the node store, walks insert paths and searches
// the quadtree depth first for a query, reading then evaluating each node.
// ----------------------------------------------------------------------------
module rrmq_walker #(
  parameter int unsigned COORD_BITS = 5,
  parameter int unsigned SEQ_BITS   = 16,
  parameter int unsigned NODE_COUNT = 1365,
  parameter int unsigned AW         = 11,
  parameter int unsigned EW         = 59
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rrmq_in_if.sink       in_i,
  rrmq_out_if.source    out_o,
  output logic          ram_we_o,
  output logic [AW-1:0] ram_addr_o,
  output logic [EW-1:0] ram_wdata_o,
  input  logic [EW-1:0] ram_rdata_i
);
  import rrmq_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned KW = EW - 1;
  localparam int unsigned LW = $clog2(COORD_BITS + 1);

  state_e state_q, state_d;

  logic [LW-1:0]          lev_q, lev_d;
  logic [PW-1:0]          path_q, path_d;
  logic                   op_q, op_d;
  logic [SEQ_BITS-1:0]    seq_q, seq_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [PRICE_W-1:0]     price_q, price_d;
  logic [CB-1:0]          px_q, px_d, py_q, py_d;
  logic [CB-1:0]          xl_q, xl_d, xh_q, xh_d, yl_q, yl_d, yh_q, yh_d;
  logic                   bvld_q, bvld_d;
  logic [KW-1:0]          bkey_q, bkey_d;

  logic                   ovld_q, ovld_d;
  logic                   ofound_q, ofound_d;
  logic [PRICE_W-1:0]     oprice_q, oprice_d;
  logic [CB-1:0]          ox_q, ox_d, oy_q, oy_d;

  logic [PW-1:0]          base;
  logic [PW-1:0]          prefix;
  logic [AW-1:0]          node_addr;
  logic [CB-1:0]          lox, loy, span, hix, hiy;
  logic [PW:0]            nxt_sum;
  logic [LW-1:0]          nxt_lev;
  logic [PW-1:0]          ins_path;
  logic [EW-1:0]          cand;
  logic                   e_vld;
  logic [KW-1:0]          e_key;
  logic                   overlap, covered, at_leaf;
  logic                   in_acc, out_acc;

  // Strict order on entries; an empty entry is the largest. The price is
  // signed, so its top bit is flipped for an unsigned compare.
  function automatic logic entry_less(input logic a_vld, input logic [KW-1:0] a_key,
                                      input logic b_vld, input logic [KW-1:0] b_key);
    logic [KW-1:0] ka;
    logic [KW-1:0] kb;
    ka = {~a_key[KW-1], a_key[KW-2:0]};
    kb = {~b_key[KW-1], b_key[KW-2:0]};
    return a_vld && (!b_vld || (ka < kb));
  endfunction

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = ovld_q && out_o.ready;

  // Node index: level base plus the path prefix above the current level.
  always_comb begin
    base = '0;
    for (int i = 0; i < CB; i++) begin
      if (i < int'(lev_q)) base[2*i] = 1'b1;
    end
    prefix    = path_q >> (PW - 2 * int'(lev_q));
    node_addr = AW'(base) + AW'(prefix);
  end

  // Node square bounds from the interleaved path.
  always_comb begin
    for (int i = 0; i < CB; i++) begin
      lox[i] = path_q[2*i];
      loy[i] = path_q[2*i+1];
    end
    span = CB'((32'd1 << (CB - int'(lev_q))) - 32'd1);
    hix  = lox | span;
    hiy  = loy | span;
  end

  // Next node after this subtree: bump the digit of this level and pop
  // back to the lowest digit that is nonzero.
  always_comb begin
    nxt_sum = {1'b0, path_q} + ((PW + 1)'(1) << (PW - 2 * int'(lev_q)));
    nxt_lev = '0;
    for (int d = CB - 1; d >= 0; d--) begin
      if (nxt_sum[2*d +: 2] != 2'b00) nxt_lev = LW'(CB - d);
    end
  end

  // Interleaved leaf path of an incoming point.
  always_comb begin
    for (int i = 0; i < CB; i++) begin
      ins_path[2*i]   = in_i.point_x[i];
      ins_path[2*i+1] = in_i.point_y[i];
    end
  end

  assign cand    = {1'b1, price_q, seq_q, px_q, py_q};
  assign e_vld   = ram_rdata_i[EW-1];
  assign e_key   = ram_rdata_i[KW-1:0];
  assign overlap = !(xh_q < lox || xl_q > hix || yh_q < loy || yl_q > hiy);
  assign covered = (xl_q <= lox) && (xh_q >= hix) && (yl_q <= loy) && (yh_q >= hiy);
  assign at_leaf = (lev_q == LW'(CB));

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    lev_d    = lev_q;
    path_d   = path_q;
    op_d     = op_q;
    seq_d    = seq_q;
    clr_d    = clr_q;
    price_d  = price_q;
    px_d     = px_q;
    py_d     = py_q;
    xl_d     = xl_q;
    xh_d     = xh_q;
    yl_d     = yl_q;
    yh_d     = yh_q;
    bvld_d   = bvld_q;
    bkey_d   = bkey_q;
    ovld_d   = ovld_q && !out_acc;
    ofound_d = ofound_q;
    oprice_d = oprice_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    ram_we_o    = 1'b0;
    ram_addr_o  = node_addr;
    ram_wdata_o = cand;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == AW'(NODE_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = in_i.operation;
          price_d = in_i.point_price;
          px_d    = in_i.point_x;
          py_d    = in_i.point_y;
          xl_d    = in_i.x_low;
          xh_d    = in_i.x_high;
          yl_d    = in_i.y_low;
          yh_d    = in_i.y_high;
          lev_d   = '0;
          path_d  = (in_i.operation == OP_INSERT) ? ins_path : '0;
          bvld_d  = 1'b0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (op_q == OP_INSERT) begin
          // Update this node on the way down, then step one level deeper or, at the leaf, finish.
          ram_we_o = entry_less(1'b1, cand[KW-1:0], e_vld, e_key);
          if (at_leaf) begin
            if (seq_q != '1) seq_d = seq_q + 1'b1;
            state_d = ST_IDLE;
          end else begin
            lev_d   = lev_q + 1'b1;
            state_d = ST_READ;
          end
        end else begin
          if (e_vld && overlap && !covered && !at_leaf) begin
            lev_d   = lev_q + 1'b1;
            state_d = ST_READ;
          end else begin
            if (e_vld && overlap && covered &&
                entry_less(e_vld, e_key, bvld_q, bkey_q)) begin
              bvld_d = 1'b1;
              bkey_d = e_key;
            end
            if (nxt_sum[PW]) begin
              state_d = ST_DONE;
            end else begin
              path_d  = nxt_sum[PW-1:0];
              lev_d   = nxt_lev;
              state_d = ST_READ;
            end
          end
        end
      end
      ST_DONE: begin
        if (!ovld_q || out_o.ready) begin
          ovld_d   = 1'b1;
          ofound_d = bvld_q;
          oprice_d = bvld_q ? bkey_q[KW-1 -: PRICE_W] : '0;
          ox_d     = bvld_q ? bkey_q[2*CB-1:CB] : '0;
          oy_d     = bvld_q ? bkey_q[CB-1:0] : '0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      seq_q   <= '0;
      ovld_q  <= 1'b0;
      bvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      seq_q   <= seq_d;
      ovld_q  <= ovld_d;
      bvld_q  <= bvld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lev_q    <= lev_d;
    path_q   <= path_d;
    op_q     <= op_d;
    price_q  <= price_d;
    px_q     <= px_d;
    py_q     <= py_d;
    xl_q     <= xl_d;
    xh_q     <= xh_d;
    yl_q     <= yl_d;
    yh_q     <= yh_d;
    bkey_q   <= bkey_d;
    ofound_q <= ofound_d;
    oprice_q <= oprice_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = ovld_q;
  assign out_o.found      = ofound_q;
  assign out_o.best_price = oprice_q;
  assign out_o.best_x     = ox_q;
  assign out_o.best_y     = oy_q;

endmodule

>>> rtl/rect_range_min_quadtree.sv
// ----------------------------------------------------------------------------
// rect_range_min_quadtree
// Minimum-price point search over rectangles of a square grid, kept in an
// implicit quadtree that lives in one synchronous node memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one word per request: an insert (point and signed price) or
//   a query (inclusive rectangle). out_o carries one word per query with the
//   found flag and the cheapest point; ties go to the earliest insert, then
//   smaller x, then smaller y. Inserts give no word.
//   Each visited tree node costs one memory read and one evaluate step.
//   An insert walks COORD_BITS+1 levels. The nodes a query visits depend
//   on the rectangle and on which nodes are occupied.
//   After reset the block sweeps all (4^(COORD_BITS+1)-1)/3 node entries
//   (1365 at default) empty, one entry a cycle, with in_i.ready low.
//   The result sits in an output register: the next request is accepted
//   while it waits, and a finished query holds until out_o.ready frees it.
// ----------------------------------------------------------------------------
module rect_range_min_quadtree #(
  parameter int unsigned COORD_BITS = 5,
  parameter int unsigned SEQ_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrmq_in_if.sink    in_i,
  rrmq_out_if.source out_o
);
  import rrmq_pkg::*;

  localparam int unsigned NodeCount = ((1 << (2 * (COORD_BITS + 1))) - 1) / 3;
  localparam int unsigned Aw        = $clog2(NodeCount);
  localparam int unsigned Ew        = 1 + PRICE_W + SEQ_BITS + 2 * COORD_BITS;

  logic          ram_we;
  logic [Aw-1:0] ram_addr;
  logic [Ew-1:0] ram_wdata;
  logic [Ew-1:0] ram_rdata;

  // Traversal control.
  rrmq_walker #(
    .COORD_BITS (COORD_BITS),
    .SEQ_BITS   (SEQ_BITS),
    .NODE_COUNT (NodeCount),
    .AW         (Aw),
    .EW         (Ew)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  // Node minimum store.
  rrmq_node_ram #(
    .DEPTH (NodeCount),
    .AW    (Aw),
    .DW    (Ew)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

>>> rtl/rrmq_checker.sv
// ----------------------------------------------------------------------------
// rrmq_checker
// Port-level checks of the range-minimum quadtree block.
// ----------------------------------------------------------------------------
module rrmq_checker #(
  parameter int unsigned COORD_BITS = 5
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   in_operation_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic                   out_found_i,
  input logic [31:0]            out_best_price_i,
  input logic [COORD_BITS-1:0]  out_best_x_i,
  input logic [COORD_BITS-1:0]  out_best_y_i
);
  import rrmq_pkg::*;

  // A word waiting on the result channel stays until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A miss reports zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |->
      out_best_price_i == '0 && out_best_x_i == '0 && out_best_y_i == '0)
    else $error("miss carries nonzero fields");

  // One request at a time: ready drops after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request accepted while busy");

  // An insert never produces a result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_operation_i == OP_INSERT |=> !$rose(out_valid_i))
    else $error("result word after an insert");

endmodule

bind rect_range_min_quadtree rrmq_checker #(
  .COORD_BITS (COORD_BITS)
) u_rrmq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_operation_i   (in_i.operation),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_found_i      (out_o.found),
  .out_best_price_i (out_o.best_price),
  .out_best_x_i     (out_o.best_x),
  .out_best_y_i     (out_o.best_y)
);

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the rectangle range-minimum quadtree. Insert
// and query words are sent through the request channel while a grid model
// predicts the answer of each query; each result word is checked against
// the oldest predicted answer.
// ----------------------------------------------------------------------------
module tb_top;
  import rrmq_pkg::*;

  localparam int unsigned COORD_BITS = 5;
  localparam int unsigned GRID       = 1 << COORD_BITS;
  localparam int unsigned SEQ_TOP    = (1 << 16) - 1;
  localparam int          PRICE_MAX  = 32'h7fff_ffff;
  localparam int          PRICE_MIN  = 32'h8000_0000;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                      found;
    logic signed [PRICE_W-1:0] price;
    coord_t                    x;
    coord_t                    y;
  } answer_t;

  logic clk;
  logic rst_n;

  rrmq_in_if  #(.COORD_BITS(COORD_BITS)) in_bus ();
  rrmq_out_if #(.COORD_BITS(COORD_BITS)) out_bus ();

  rect_range_min_quadtree #(
    .COORD_BITS(COORD_BITS),
    .SEQ_BITS  (16)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Grid model: per cell the cheapest point inserted there.
  logic                      cell_used  [GRID][GRID];
  logic signed [PRICE_W-1:0] cell_price [GRID][GRID];
  int unsigned               cell_seq   [GRID][GRID];
  int unsigned               insert_seq;

  answer_t     pending_answers[$];
  int unsigned mismatch_count;
  int unsigned orphan_count;

  // Sender and receiver pacing.
  int unsigned gap_max;
  int unsigned burst_left;
  int unsigned stall_pct;
  int unsigned hold_left;

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog.
  initial begin
    #500ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Record one accepted insert in the grid model.
  function automatic void model_insert(coord_t px, coord_t py, logic signed [31:0] price);
    if (!cell_used[px][py] || price < cell_price[px][py]) begin
      cell_used[px][py]  = 1'b1;
      cell_price[px][py] = price;
      cell_seq[px][py]   = insert_seq;
    end
    if (insert_seq < SEQ_TOP) insert_seq++;
  endfunction

  // Cheapest point inside the rectangle; ties by insertion order, x, then y.
  function automatic answer_t cheapest_in_rect(coord_t xl, coord_t xh, coord_t yl, coord_t yh);
    answer_t     best;
    int unsigned best_seq;
    best     = '0;
    best_seq = 0;
    for (int xi = int'(xl); xi <= int'(xh); xi++) begin
      for (int yi = int'(yl); yi <= int'(yh); yi++) begin
        if (cell_used[xi][yi] && (!best.found || cell_price[xi][yi] < best.price ||
            (cell_price[xi][yi] == best.price && cell_seq[xi][yi] < best_seq))) begin
          best.found = 1'b1;
          best.price = cell_price[xi][yi];
          best.x     = coord_t'(xi);
          best.y     = coord_t'(yi);
          best_seq   = cell_seq[xi][yi];
        end
      end
    end
    return best;
  endfunction

  // Send one word, honoring the burst pattern; returns at the falling edge
  // after acceptance with valid still high.
  task automatic send_word(logic op, coord_t px, coord_t py, logic signed [31:0] price,
                           coord_t xl, coord_t xh, coord_t yl, coord_t yh);
    int unsigned gap;
    if (gap_max > 0 && burst_left == 0) begin
      in_bus.valid <= 1'b0;
      gap = $urandom_range(1, gap_max);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    in_bus.operation   <= op;
    in_bus.point_x     <= px;
    in_bus.point_y     <= py;
    in_bus.point_price <= price;
    in_bus.x_low       <= xl;
    in_bus.x_high      <= xh;
    in_bus.y_low       <= yl;
    in_bus.y_high      <= yh;
    in_bus.valid       <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    if (op == OP_INSERT) model_insert(px, py, price);
    else pending_answers.push_back(cheapest_in_rect(xl, xh, yl, yh));
    @(negedge clk);
  endtask

  // Insert a point; the rectangle fields carry noise.
  task automatic insert_point(int px, int py, int price);
    send_word(OP_INSERT, coord_t'(px), coord_t'(py), price,
              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom));
  endtask

  // Query a rectangle; the point fields carry noise.
  task automatic query_rect(int xl, int xh, int yl, int yh);
    send_word(OP_QUERY, coord_t'($urandom), coord_t'($urandom), $signed($urandom),
              coord_t'(xl), coord_t'(xh), coord_t'(yl), coord_t'(yh));
  endtask

  task automatic sender_idle();
    in_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    sender_idle();
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] random_price();
    if ($urandom_range(2) == 0) return $urandom;
    return $signed($urandom_range(8)) - 4;
  endfunction

  // Mostly small rectangles, sometimes wide or inverted ones.
  task automatic random_query();
    int xl, xh, yl, yh;
    if ($urandom_range(4) == 0) begin
      query_rect(int'($urandom_range(GRID - 1)), int'($urandom_range(GRID - 1)),
                 int'($urandom_range(GRID - 1)), int'($urandom_range(GRID - 1)));
    end else begin
      xl = int'($urandom_range(GRID - 1));
      yl = int'($urandom_range(GRID - 1));
      xh = xl + int'($urandom_range(7));
      yh = yl + int'($urandom_range(7));
      if (xh > int'(GRID) - 1) xh = int'(GRID) - 1;
      if (yh > int'(GRID) - 1) yh = int'(GRID) - 1;
      query_rect(xl, xh, yl, yh);
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.found, out_bus.best_price, out_bus.best_x, out_bus.best_y};
      if (pending_answers.size() == 0) begin
        orphan_count++;
        if (mismatch_count + orphan_count <= 10)
          $display("%0t: result word with no query outstanding", $realtime);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count + orphan_count <= 10)
            $display("%0t: found %0b/%0b price %0d/%0d x %0d/%0d y %0d/%0d (exp/got)",
                     $realtime, want.found, got.found, want.price, got.price,
                     want.x, got.x, want.y, got.y);
        end
      end
    end
  end

  // Extremes, ties, empty and inverted rectangles.
  task automatic test_directed();
    query_rect(0, GRID - 1, 0, GRID - 1);
    insert_point(0, 0, PRICE_MIN);
    insert_point(GRID - 1, GRID - 1, PRICE_MAX);
    insert_point(5, 9, -1);
    insert_point(9, 5, -1);
    insert_point(3, 3, 7);
    insert_point(3, 3, 7);
    query_rect(0, GRID - 1, 0, GRID - 1);
    query_rect(1, GRID - 1, 1, GRID - 1);
    query_rect(4, GRID - 1, 0, GRID - 1);
    query_rect(GRID - 1, GRID - 1, GRID - 1, GRID - 1);
    query_rect(3, 3, 3, 3);
    query_rect(10, 20, 10, 20);
    query_rect(GRID - 1, 0, 0, GRID - 1);
    query_rect(0, GRID - 1, GRID - 1, 0);
    query_rect(6, 5, 6, 5);
    insert_point(10, 21, 0);
    insert_point(21, 10, 0);
    query_rect(10, 21, 10, 21);
    query_rect(0, 31, 10, 10);
  endtask

  // Random mixture under sender gaps and receiver stalls.
  task automatic test_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ((n % 300) == 0) begin
        gap_max   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30);
        stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 80);
      end
      if ($urandom_range(9) < 4) insert_point($urandom, $urandom, random_price());
      else random_query();
    end
  endtask

  // Long receiver hold-off while queries keep coming.
  task automatic test_backpressure();
    gap_max   = 0;
    stall_pct = 0;
    hold_left = 600;
    for (int n = 0; n < 40; n++) random_query();
    wait_drained();
  endtask

  // Sender pauses until all answers are back, then resumes.
  task automatic test_pause();
    for (int n = 0; n < 20; n++) random_query();
    wait_drained();
    for (int n = 0; n < 20; n++) begin
      insert_point($urandom, $urandom, random_price());
      random_query();
    end
  endtask

  // Equal lowest prices at several points: the earliest insert wins even
  // against a smaller x or y.
  task automatic test_price_ties();
    gap_max   = 0;
    stall_pct = 0;
    insert_point(20, 4, PRICE_MIN);
    insert_point(3, 30, PRICE_MIN);
    insert_point(3, 2, PRICE_MIN);
    insert_point(1, 30, PRICE_MIN);
    query_rect(0, GRID - 1, 0, GRID - 1);
    query_rect(2, GRID - 1, 0, GRID - 1);
    query_rect(3, GRID - 1, 3, GRID - 1);
    query_rect(4, GRID - 1, 0, GRID - 1);
    wait_drained();
  endtask

  initial begin
    in_bus.valid       = 1'b0;
    in_bus.operation   = OP_INSERT;
    in_bus.point_x     = '0;
    in_bus.point_y     = '0;
    in_bus.point_price = '0;
    in_bus.x_low       = '0;
    in_bus.x_high      = '0;
    in_bus.y_low       = '0;
    in_bus.y_high      = '0;
    out_bus.ready      = 1'b0;
    gap_max        = 0;
    burst_left     = 0;
    stall_pct      = 0;
    hold_left      = 0;
    insert_seq     = 0;
    mismatch_count = 0;
    orphan_count   = 0;
    foreach (cell_used[i, j]) begin
      cell_used[i][j]  = 1'b0;
      cell_price[i][j] = '0;
      cell_seq[i][j]   = 0;
    end
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(1800);
    test_backpressure();
    test_pause();
    test_price_ties();

    // Let any last insert walk finish before the verdict.
    wait_drained();
    repeat (50) @(negedge clk);
    if (mismatch_count == 0 && orphan_count == 0 && pending_answers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
